// ===== hdl/sdrx_pkg.sv =====
// shared types, constants and crc function for the sd spi data block receiver
package sdrx_pkg;

    // default size limits
    localparam int MAX_BLOCK_LEN_DEF = 4096;

    // field widths
    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int BLK_LEN_W   = 13;
    localparam int WAIT_W      = 16;
    localparam int CRC_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CMP_W       = 17;
    localparam int PHASE_W     = 3;

    // stream packing widths
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_WAIT   = 2'd1;

    // configuration reset values
    localparam logic [BLK_LEN_W-1:0] BLOCK_LENGTH_RST = 13'd512;
    localparam logic [WAIT_W-1:0]    TOKEN_WAIT_RST   = 16'd60000;

    // input op codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CRC_ERR = 2'd2;

    // token and crc constants
    localparam logic [BYTE_W-1:0] TOKEN_START = 8'hFE;
    localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_TOKEN  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DATA   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_CRC_HI = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CRC_LO = 3'd4;

    // one result item
    typedef struct packed {
        logic                kind;
        logic [BYTE_W-1:0]   data_byte;
        logic [STATUS_W-1:0] status;
        logic                last;
    } sdrx_res_t;

    // crc-16 ccitt, msb first, one byte
    function automatic logic [CRC_W-1:0] crc16_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data_in
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {data_in, 8'h00};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== hdl/sdrx_core.sv =====
// block read sequencer: token hunt with timeout, data forwarding, crc check
module sdrx_core
    import sdrx_pkg::*;
#(
    parameter int MAX_BLOCK_LEN = MAX_BLOCK_LEN_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 op,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic [BLK_LEN_W-1:0] block_length,
    input  logic [WAIT_W-1:0]    token_wait_limit,
    output logic                 res_valid,
    output sdrx_res_t            res
);

    localparam int CNT_W = $clog2(MAX_BLOCK_LEN + 1);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [WAIT_W-1:0]  wait_left_reg, wait_left_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CRC_W-1:0]   crc_reg, crc_next;
    logic [BYTE_W-1:0]  crc_hi_reg, crc_hi_next;

    logic [CMP_W-1:0]   len_ext;
    logic [CMP_W-1:0]   max_ext;
    logic [CMP_W-1:0]   eff_len;
    logic [CMP_W-1:0]   cnt_inc;
    logic [WAIT_W-1:0]  wait_dec;
    logic [CRC_W-1:0]   crc_upd;

    // effective block length, saturated to the build limit
    assign len_ext = CMP_W'(block_length);
    assign max_ext = CMP_W'(MAX_BLOCK_LEN);
    assign eff_len = (len_ext > max_ext) ? max_ext : len_ext;

    assign cnt_inc  = CMP_W'(count_reg) + CMP_W'(1);
    assign wait_dec = wait_left_reg - WAIT_W'(1);
    assign crc_upd  = crc16_byte(crc_reg, rx_byte);

    // next state and result
    always_comb
    begin
        phase_next     = phase_reg;
        wait_left_next = wait_left_reg;
        count_next     = count_reg;
        crc_next       = crc_reg;
        crc_hi_next    = crc_hi_reg;
        res_valid      = 1'b0;
        res.kind       = KIND_DATA;
        res.data_byte  = '0;
        res.status     = ST_OK;
        res.last       = 1'b0;
        if (step)
        begin
            if (op == OP_START)
            begin
                phase_next     = PH_TOKEN;
                wait_left_next = (token_wait_limit != '0) ? token_wait_limit : WAIT_W'(1);
                count_next     = '0;
                crc_next       = '0;
                crc_hi_next    = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_TOKEN:
                    begin
                        if (rx_byte == TOKEN_START)
                        begin
                            count_next = '0;
                            crc_next   = '0;
                            phase_next = (eff_len == '0) ? PH_CRC_HI : PH_DATA;
                        end
                        else
                        begin
                            wait_left_next = wait_dec;
                            // last try used up
                            if (wait_dec == '0)
                            begin
                                phase_next = PH_IDLE;
                                res_valid  = 1'b1;
                                res.kind   = KIND_STATUS;
                                res.status = ST_TIMEOUT;
                                res.last   = 1'b1;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        crc_next      = crc_upd;
                        count_next    = CNT_W'(cnt_inc);
                        if (cnt_inc >= eff_len)
                            phase_next = PH_CRC_HI;
                        res_valid     = 1'b1;
                        res.kind      = KIND_DATA;
                        res.data_byte = rx_byte;
                    end
                    PH_CRC_HI:
                    begin
                        crc_hi_next = rx_byte;
                        phase_next  = PH_CRC_LO;
                    end
                    PH_CRC_LO:
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res.kind   = KIND_STATUS;
                        res.status = ({crc_hi_reg, rx_byte} == crc_reg) ? ST_OK : ST_CRC_ERR;
                        res.last   = 1'b1;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            wait_left_reg <= '0;
            count_reg     <= '0;
            crc_reg       <= '0;
            crc_hi_reg    <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            wait_left_reg <= wait_left_next;
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            crc_hi_reg    <= crc_hi_next;
        end
    end

endmodule

// ===== hdl/sd_spi_data_block_receiver_top.sv =====
// top level: stream ports, config registers, input and result registers
// a byte accepted into the input register is stepped by the sequencer and its result is held in the result register
// throughput: one item per cycle while the result side is ready, set by the single-pass sequencer stage
// the input register takes a new item while a result waits on the output only if the input register is empty
// reset: rst_n async low; sequencer idle, block_length 512, token wait 60000
module sd_spi_data_block_receiver_top
    import sdrx_pkg::*;
#(
    parameter int MAX_BLOCK_LEN = MAX_BLOCK_LEN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    input  logic [0:0]            s_tuser,   // [0] op
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] data_byte, [9:8] status, rest zero
    output logic [0:0]            m_tuser,   // [0] kind
    output logic                  m_tlast,
    // config writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic                 in_valid_reg;
    logic                 in_op_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 out_valid_reg;
    sdrx_res_t            out_reg;
    logic [BLK_LEN_W-1:0] block_length_reg;
    logic [WAIT_W-1:0]    wait_limit_reg;

    logic                 adv;
    logic                 core_step;
    logic                 core_res_valid;
    sdrx_res_t            core_res;

    // handshakes
    assign adv       = !out_valid_reg || m_tready;
    assign core_step = in_valid_reg && adv;
    assign s_tready  = !in_valid_reg || adv;
    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_length_reg <= BLOCK_LENGTH_RST;
            wait_limit_reg   <= TOKEN_WAIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BLOCK_LENGTH: block_length_reg <= cfg_data[BLK_LEN_W-1:0];
                CFG_TOKEN_WAIT:   wait_limit_reg   <= cfg_data[WAIT_W-1:0];
                default:          block_length_reg <= block_length_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser[0];
            in_byte_reg <= s_tdata[BYTE_W-1:0];
        end
    end

    sdrx_core #(
        .MAX_BLOCK_LEN (MAX_BLOCK_LEN)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (core_step),
        .op               (in_op_reg),
        .rx_byte          (in_byte_reg),
        .block_length     (block_length_reg),
        .token_wait_limit (wait_limit_reg),
        .res_valid        (core_res_valid),
        .res              (core_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= core_step && core_res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (core_step && core_res_valid)
            out_reg <= core_res;
    end

    // output packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - BYTE_W - STATUS_W){1'b0}}, out_reg.status,
                       out_reg.data_byte};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule

// ===== sim/tb_sd_spi_data_block_receiver_top.sv =====
// self-checking testbench for the sd spi data block receiver top level
module tb_sd_spi_data_block_receiver_top;
    import sdrx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // limits and run shaping
    localparam int          MAX_LEN      = MAX_BLOCK_LEN_DEF;
    localparam int          STALL_LIMIT  = 5000;
    localparam int          SETTLE       = 4;
    localparam int          PHASE_ITEMS  = 150;
    localparam int          NUM_PHASES   = 11;
    localparam logic [1:0]  CFG_SPARE_A  = 2'd2;
    localparam logic [1:0]  CFG_SPARE_B  = 2'd3;

    // directed table row layout
    typedef enum logic [1:0] {ACT_ITEM, ACT_CFG} act_t;
    typedef enum logic [1:0] {SRC_LIT, SRC_CRC_HI, SRC_CRC_LO} src_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_RES} chk_t;

    typedef struct packed {
        act_t             act;
        src_t             src;
        logic [1:0]       idx;
        logic [15:0]      val;
        logic             op;
        chk_t             chk;
        sdrx_res_t        res;
    } dir_row_t;

    // results that can be read straight off the spec
    localparam sdrx_res_t NO_RES    = '0;
    localparam sdrx_res_t R_DATA00  = '{KIND_DATA, 8'h00, ST_OK, 1'b0};
    localparam sdrx_res_t R_DATAFF  = '{KIND_DATA, 8'hFF, ST_OK, 1'b0};
    localparam sdrx_res_t R_OK      = '{KIND_STATUS, 8'h00, ST_OK, 1'b1};
    localparam sdrx_res_t R_TIMEOUT = '{KIND_STATUS, 8'h00, ST_TIMEOUT, 1'b1};

    localparam int DIR_ROWS = 38;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // short blocks, short token wait
        '{ACT_CFG,  SRC_LIT,    CFG_BLOCK_LENGTH, 16'd2,    OP_BYTE,  CHK_NONE,  NO_RES},
        '{ACT_CFG,  SRC_LIT,    CFG_TOKEN_WAIT,   16'd3,    OP_BYTE,  CHK_NONE,  NO_RES},
        // byte while idle is dropped
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h0000, OP_BYTE,  CHK_NONE,  NO_RES},
        // clean read with extreme data bytes
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h00A5, OP_START, CHK_NONE,  NO_RES},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h00FE, OP_BYTE,  CHK_NONE,  NO_RES},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h0000, OP_BYTE,  CHK_RES,   R_DATA00},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h00FF, OP_BYTE,  CHK_RES,   R_DATAFF},
        '{ACT_ITEM, SRC_CRC_HI, 2'd0, 16'h0000, OP_BYTE,  CHK_NONE,  NO_RES},
        '{ACT_ITEM, SRC_CRC_LO, 2'd0, 16'h0000, OP_BYTE,  CHK_RES,   R_OK},
        // token never shows up
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h0000, OP_START, CHK_NONE,  NO_RES},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h0000, OP_BYTE,  CHK_NONE,  NO_RES},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h00FF, OP_BYTE,  CHK_NONE,  NO_RES},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h0001, OP_BYTE,  CHK_RES,   R_TIMEOUT},
        // wrong crc bytes
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h00FF, OP_START, CHK_NONE,  NO_RES},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h00FE, OP_BYTE,  CHK_NONE,  NO_RES},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h005A, OP_BYTE,  CHK_MODEL, NO_RES},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h00A5, OP_BYTE,  CHK_MODEL, NO_RES},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h0000, OP_BYTE,  CHK_MODEL, NO_RES},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h0000, OP_BYTE,  CHK_MODEL, NO_RES},
        // restart in the middle of a block
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h003C, OP_START, CHK_NONE,  NO_RES},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h00FE, OP_BYTE,  CHK_NONE,  NO_RES},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h0011, OP_BYTE,  CHK_MODEL, NO_RES},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h00C3, OP_START, CHK_NONE,  NO_RES},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h00FE, OP_BYTE,  CHK_NONE,  NO_RES},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h0080, OP_BYTE,  CHK_MODEL, NO_RES},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h007F, OP_BYTE,  CHK_MODEL, NO_RES},
        '{ACT_ITEM, SRC_CRC_HI, 2'd0, 16'h0000, OP_BYTE,  CHK_MODEL, NO_RES},
        '{ACT_ITEM, SRC_CRC_LO, 2'd0, 16'h0000, OP_BYTE,  CHK_MODEL, NO_RES},
        // zero length, zero wait, writes to unused indexes
        '{ACT_CFG,  SRC_LIT,    CFG_BLOCK_LENGTH, 16'd0,    OP_BYTE,  CHK_NONE,  NO_RES},
        '{ACT_CFG,  SRC_LIT,    CFG_TOKEN_WAIT,   16'd0,    OP_BYTE,  CHK_NONE,  NO_RES},
        '{ACT_CFG,  SRC_LIT,    CFG_SPARE_A,      16'hFFFF, OP_BYTE,  CHK_NONE,  NO_RES},
        '{ACT_CFG,  SRC_LIT,    CFG_SPARE_B,      16'h1234, OP_BYTE,  CHK_NONE,  NO_RES},
        // wait limit of zero behaves as one
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h0000, OP_START, CHK_NONE,  NO_RES},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h007F, OP_BYTE,  CHK_RES,   R_TIMEOUT},
        // empty block: crc bytes right after the token, checked against zero
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h0000, OP_START, CHK_NONE,  NO_RES},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h00FE, OP_BYTE,  CHK_NONE,  NO_RES},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h0000, OP_BYTE,  CHK_NONE,  NO_RES},
        '{ACT_ITEM, SRC_LIT,    2'd0, 16'h0000, OP_BYTE,  CHK_RES,   R_OK}
    };

    // per-phase register settings for the random part
    // upper bits of a block length write above bit 12 are dropped by the register
    localparam logic [15:0] PH_BLK [NUM_PHASES] =
        '{16'd1, 16'd5, 16'd0, 16'hE00A, 16'd3, 16'd12, 16'd2, 16'd7, 16'd11, 16'd9, 16'd1};
    localparam logic [15:0] PH_WAIT [NUM_PHASES] =
        '{16'd1, 16'd4, 16'd2, 16'd65535, 16'd0, 16'd60000, 16'd6, 16'd3, 16'd5, 16'd10, 16'd2};

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // shadow of the receiver registers and sequencer
    logic [BLK_LEN_W-1:0]  shadow_blk_len;
    logic [WAIT_W-1:0]     shadow_wait_lim;
    logic [PHASE_W-1:0]    rx_phase;
    logic [WAIT_W-1:0]     rx_wait_left;
    logic [15:0]           rx_count;
    logic [CRC_W-1:0]      rx_crc;
    logic [BYTE_W-1:0]     rx_crc_hi;

    sdrx_res_t             pending_results[$];
    bit                    calm;
    int                    n_errs;
    int                    n_items;
    int                    n_data;
    int                    n_ok;
    int                    n_timeout;
    int                    n_crc_err;
    int                    idle_cycles;

    sd_spi_data_block_receiver_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // crc-16, poly 0x1021, one byte msb first
    function automatic logic [CRC_W-1:0] crc16_next(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = crc;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            fb = c[CRC_W-1] ^ b[i];
            c  = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
        end
        return c;
    endfunction

    // advance the shadow receiver by one byte; returns 1 when a result comes out
    function automatic bit advance_block_rx(input logic op, input logic [BYTE_W-1:0] b,
                                            output sdrx_res_t r);
        logic [BLK_LEN_W-1:0] len;
        logic [CRC_W-1:0]     word;
        r   = '0;
        len = (shadow_blk_len > MAX_LEN) ? BLK_LEN_W'(MAX_LEN) : shadow_blk_len;
        if (op == OP_START)
        begin
            rx_phase     = PH_TOKEN;
            rx_wait_left = (shadow_wait_lim == 0) ? WAIT_W'(1) : shadow_wait_lim;
            rx_count     = '0;
            rx_crc       = '0;
            rx_crc_hi    = '0;
            return 1'b0;
        end
        case (rx_phase)
            PH_TOKEN:
            begin
                if (b == TOKEN_START)
                begin
                    rx_count = '0;
                    rx_crc   = '0;
                    rx_phase = (len == 0) ? PH_CRC_HI : PH_DATA;
                    return 1'b0;
                end
                rx_wait_left = rx_wait_left - 1'b1;
                if (rx_wait_left == 0)
                begin
                    rx_phase = PH_IDLE;
                    r = '{KIND_STATUS, 8'h00, ST_TIMEOUT, 1'b1};
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_DATA:
            begin
                rx_crc   = crc16_next(rx_crc, b);
                rx_count = rx_count + 1'b1;
                if (rx_count >= len)
                    rx_phase = PH_CRC_HI;
                r = '{KIND_DATA, b, ST_OK, 1'b0};
                return 1'b1;
            end
            PH_CRC_HI:
            begin
                rx_crc_hi = b;
                rx_phase  = PH_CRC_LO;
                return 1'b0;
            end
            PH_CRC_LO:
            begin
                word     = {rx_crc_hi, b};
                rx_phase = PH_IDLE;
                r = '{KIND_STATUS, 8'h00, (word == rx_crc) ? ST_OK : ST_CRC_ERR, 1'b1};
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // one line per mismatch, counted
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        n_errs++;
    endtask

    // send one input transaction, then queue what it should produce
    task automatic send_item(input logic op, input logic [BYTE_W-1:0] b,
                             input chk_t chk = CHK_MODEL, input sdrx_res_t want = '0);
        sdrx_res_t r;
        bit        got;
        bit        ignored;
        if (!calm && $urandom_range(99) < 7)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid   <= 1'b1;
        s_tdata    <= b;
        s_tuser[0] <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ignored = (op == OP_BYTE) && (rx_phase == PH_IDLE);
        got     = advance_block_rx(op, b, r);
        if (chk == CHK_MODEL && got)
            pending_results.push_back(r);
        else if (chk == CHK_RES)
            pending_results.push_back(want);
        if (!ignored)
            n_items++;
    endtask

    // hold the sender off until every result is back, then let the pipe settle
    task automatic wait_results(input int settle);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // register write while the receiver is idle
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_results(SETTLE);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_BLOCK_LENGTH)
            shadow_blk_len = val[BLK_LEN_W-1:0];
        else if (idx == CFG_TOKEN_WAIT)
            shadow_wait_lim = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // any byte but the start token
    function automatic logic [BYTE_W-1:0] filler_byte();
        logic [BYTE_W-1:0] b;
        b = ($urandom_range(1) != 0) ? 8'hFF : BYTE_W'($urandom_range(255));
        return (b == TOKEN_START) ? 8'hFF : b;
    endfunction

    // full block read; optionally spoils one crc bit
    task automatic good_read(input bit spoil);
        int               pre;
        logic [CRC_W-1:0] crc_word;
        send_item(OP_START, BYTE_W'($urandom_range(255)));
        pre = $urandom_range(0, 3);
        if (pre >= rx_wait_left)
            pre = rx_wait_left - 1;
        repeat (pre) send_item(OP_BYTE, filler_byte());
        send_item(OP_BYTE, TOKEN_START);
        while (rx_phase == PH_DATA)
        begin
            case ($urandom_range(9))
                0:       send_item(OP_BYTE, TOKEN_START);
                1:       send_item(OP_BYTE, 8'hFF);
                2:       send_item(OP_BYTE, 8'h00);
                default: send_item(OP_BYTE, BYTE_W'($urandom_range(255)));
            endcase
        end
        crc_word = rx_crc;
        if (spoil)
            crc_word = crc_word ^ (CRC_W'(1) << $urandom_range(CRC_W - 1));
        send_item(OP_BYTE, crc_word[15:8]);
        send_item(OP_BYTE, crc_word[7:0]);
    endtask

    // one random read: mostly clean blocks, some noise and broken sequences
    task automatic random_read();
        int sel;
        int n;
        sel = $urandom_range(99);
        if (sel < 6)
        begin
            // stray bytes, dropped when idle
            repeat ($urandom_range(1, 3)) send_item(OP_BYTE, BYTE_W'($urandom_range(255)));
        end
        else if (sel < 14 && shadow_wait_lim <= 40)
        begin
            // card never sends the token
            send_item(OP_START, BYTE_W'($urandom_range(255)));
            while (rx_phase == PH_TOKEN)
                send_item(OP_BYTE, filler_byte());
        end
        else if (sel < 24)
        begin
            // read cut short; the next start abandons it
            send_item(OP_START, BYTE_W'($urandom_range(255)));
            n = $urandom_range(0, 2);
            repeat (n) send_item(OP_BYTE, filler_byte());
            if ($urandom_range(1) != 0)
                send_item(OP_BYTE, TOKEN_START);
            repeat ($urandom_range(0, 3)) send_item(OP_BYTE, BYTE_W'($urandom_range(255)));
        end
        else
            good_read($urandom_range(99) < 15);
    endtask

    // result checker
    always @(posedge clk)
    begin
        sdrx_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", m_tdata, 16'h0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser[0] != want.kind)
                    report_mismatch("kind", 16'(m_tuser[0]), 16'(want.kind));
                if (m_tdata[7:0] != want.data_byte)
                    report_mismatch("data_byte", 16'(m_tdata[7:0]), 16'(want.data_byte));
                if (m_tdata[9:8] != want.status)
                    report_mismatch("status", 16'(m_tdata[9:8]), 16'(want.status));
                if (m_tlast != want.last)
                    report_mismatch("last", 16'(m_tlast), 16'(want.last));
                if (m_tdata[15:10] != '0)
                    report_mismatch("tdata padding", m_tdata, 16'(m_tdata[9:0]));
                if (want.kind == KIND_DATA)
                    n_data++;
                else if (want.status == ST_OK)
                    n_ok++;
                else if (want.status == ST_TIMEOUT)
                    n_timeout++;
                else
                    n_crc_err++;
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        m_tready <= calm || ($urandom_range(99) >= 7);
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin
        int               base;
        logic [BYTE_W-1:0] b;
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        m_tready        = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        calm            = 1'b0;
        n_errs          = 0;
        n_items         = 0;
        n_data          = 0;
        n_ok            = 0;
        n_timeout       = 0;
        n_crc_err       = 0;
        idle_cycles     = 0;
        shadow_blk_len  = BLOCK_LENGTH_RST;
        shadow_wait_lim = TOKEN_WAIT_RST;
        rx_phase        = PH_IDLE;
        rx_wait_left    = '0;
        rx_count        = '0;
        rx_crc          = '0;
        rx_crc_hi       = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIR_TAB[i].act == ACT_CFG)
                write_cfg(DIR_TAB[i].idx, DIR_TAB[i].val);
            else
            begin
                case (DIR_TAB[i].src)
                    SRC_CRC_HI: b = rx_crc[15:8];
                    SRC_CRC_LO: b = rx_crc[7:0];
                    default:    b = DIR_TAB[i].val[7:0];
                endcase
                send_item(DIR_TAB[i].op, b, DIR_TAB[i].chk, DIR_TAB[i].res);
            end
        end

        // random phases, each under its own register setting
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_cfg(CFG_BLOCK_LENGTH, PH_BLK[p]);
            write_cfg(CFG_TOKEN_WAIT, PH_WAIT[p]);
            calm = (p == 5) || (p == 6);
            base = n_items;
            if (shadow_blk_len > 64)
                good_read(1'b0);
            else
                while (n_items - base < PHASE_ITEMS)
                    random_read();
            if (rx_phase != PH_IDLE)
                good_read(1'b0);
        end
        calm = 1'b0;

        // drain and let the pipe go quiet
        wait_results(20);
        $display("covered %0d items over %0d register settings, block lengths 0 to 12",
                 n_items, NUM_PHASES + 2);
        $display("checked %0d data bytes, %0d ok, %0d timeout, %0d crc error statuses",
                 n_data, n_ok, n_timeout, n_crc_err);
        if (n_errs == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
